// ----- hw/rtl/mrtu_pkg.sv -----
// Shared types, constants and functions for the Modbus RTU receive framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mrtu_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int MIN_FRAME_BYTES = 4;
    localparam int BYTE_COUNT_W    = $clog2(MAX_FRAME_BYTES + 1);
    localparam int PDU_OFFSET      = 3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    localparam logic [7:0] STATION_ADDRESS_RESET = 8'd10;
    localparam logic [7:0] BROADCAST_ADDRESS     = 8'd0;

    typedef enum logic [2:0] {
        ST_EMPTY  = 3'd0,
        ST_SHORT  = 3'd1,
        ST_CRC    = 3'd2,
        ST_OTHER  = 3'd3,
        ST_BCAST  = 3'd4,
        ST_OURS   = 3'd5
    } frame_status_t;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_GAP  = 1'b1
    } command_t;

    typedef struct packed {
        command_t   command;
        logic [7:0] rx_byte;
        logic       overrun_error;
        logic       parity_error;
        logic       framing_error;
    } item_t;

    typedef struct packed {
        frame_status_t frame_status;
        logic [7:0]    frame_address;
        logic [7:0]    function_code;
        logic [7:0]    pdu_length;
        logic [15:0]   frame_count;
        logic [15:0]   crc_error_count;
        logic [15:0]   short_frame_count;
        logic [15:0]   overflow_count;
        logic [15:0]   overrun_count;
        logic [15:0]   parity_error_count;
        logic [15:0]   framing_error_count;
    } result_t;

    // Modbus CRC-16, reflected, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// ----- hw/rtl/mrtu_in_stage.sv -----
// Input register of the framer: holds one accepted stream transfer.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mrtu_pkg::item_t in_item,
    output logic           item_valid,
    output mrtu_pkg::item_t item,
    input  logic           item_take
);
    import mrtu_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- hw/rtl/mrtu_frame_core.sv -----
// Frame state of the framer: running CRC, byte count, captured header and
// statistics counters; classifies the frame at each gap. Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [7:0]       cfg_data,
    input  logic             item_valid,
    input  mrtu_pkg::item_t  item,
    output logic             item_take,
    input  logic             res_ready,
    output logic             res_push,
    output mrtu_pkg::result_t res
);
    import mrtu_pkg::*;

    logic [7:0]              station_address_reg;
    logic [15:0]             crc_reg, crc_next;
    logic [BYTE_COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]              address_reg, address_next;
    logic [7:0]              function_reg, function_next;
    logic [15:0]             frames_reg, frames_next;
    logic [15:0]             crc_errors_reg, crc_errors_next;
    logic [15:0]             short_frames_reg, short_frames_next;
    logic [15:0]             overflows_reg, overflows_next;
    logic [15:0]             overruns_reg, overruns_next;
    logic [15:0]             parity_errors_reg, parity_errors_next;
    logic [15:0]             framing_errors_reg, framing_errors_next;
    frame_status_t           status;
    logic [7:0]              pdu;
    logic                    byte_error;

    // a byte never waits for the output side, a gap needs room for its result
    assign item_take  = item_valid && ((item.command == CMD_BYTE) || res_ready);
    assign res_push   = item_take && (item.command == CMD_GAP);
    assign byte_error = item.overrun_error || item.parity_error || item.framing_error;

    always_comb
    begin
        crc_next            = crc_reg;
        byte_count_next     = byte_count_reg;
        address_next        = address_reg;
        function_next       = function_reg;
        frames_next         = frames_reg;
        crc_errors_next     = crc_errors_reg;
        short_frames_next   = short_frames_reg;
        overflows_next      = overflows_reg;
        overruns_next       = overruns_reg;
        parity_errors_next  = parity_errors_reg;
        framing_errors_next = framing_errors_reg;
        status              = ST_EMPTY;
        pdu                 = 8'd0;

        if (byte_count_reg == '0)
        begin
            status = ST_EMPTY;
        end
        else if (byte_count_reg < BYTE_COUNT_W'(MIN_FRAME_BYTES))
        begin
            status = ST_SHORT;
        end
        else if (crc_reg != 16'h0000)
        begin
            status = ST_CRC;
        end
        else if (address_reg == BROADCAST_ADDRESS)
        begin
            status = ST_BCAST;
        end
        else if (address_reg == station_address_reg)
        begin
            status = ST_OURS;
        end
        else
        begin
            status = ST_OTHER;
        end

        if (status != ST_EMPTY && status != ST_SHORT)
        begin
            pdu = 8'(byte_count_reg - BYTE_COUNT_W'(PDU_OFFSET));
        end

        if (item_take)
        begin
            if (item.command == CMD_BYTE)
            begin
                if (byte_error)
                begin
                    if (item.overrun_error)
                    begin
                        overruns_next = sat_inc16(overruns_reg);
                    end
                    if (item.parity_error)
                    begin
                        parity_errors_next = sat_inc16(parity_errors_reg);
                    end
                    if (item.framing_error)
                    begin
                        framing_errors_next = sat_inc16(framing_errors_reg);
                    end
                    crc_next        = CRC_INIT;
                    byte_count_next = '0;
                    address_next    = 8'd0;
                    function_next   = 8'd0;
                end
                else if (byte_count_reg == BYTE_COUNT_W'(MAX_FRAME_BYTES))
                begin
                    // drop the byte and restart the frame
                    overflows_next  = sat_inc16(overflows_reg);
                    crc_next        = CRC_INIT;
                    byte_count_next = '0;
                    address_next    = 8'd0;
                    function_next   = 8'd0;
                end
                else
                begin
                    if (byte_count_reg == BYTE_COUNT_W'(0))
                    begin
                        address_next = item.rx_byte;
                    end
                    if (byte_count_reg == BYTE_COUNT_W'(1))
                    begin
                        function_next = item.rx_byte;
                    end
                    crc_next        = crc16_byte(crc_reg, item.rx_byte);
                    byte_count_next = byte_count_reg + BYTE_COUNT_W'(1);
                end
            end
            else
            begin
                frames_next = frames_reg + 16'd1;
                if (status == ST_SHORT)
                begin
                    short_frames_next = sat_inc16(short_frames_reg);
                end
                if (status == ST_CRC)
                begin
                    crc_errors_next = sat_inc16(crc_errors_reg);
                end
                crc_next        = CRC_INIT;
                byte_count_next = '0;
                address_next    = 8'd0;
                function_next   = 8'd0;
            end
        end
    end

    always_comb
    begin
        res.frame_status        = status;
        res.frame_address       = address_reg;
        res.function_code       = function_reg;
        res.pdu_length          = pdu;
        res.frame_count         = frames_next;
        res.crc_error_count     = crc_errors_next;
        res.short_frame_count   = short_frames_next;
        res.overflow_count      = overflows_next;
        res.overrun_count       = overruns_next;
        res.parity_error_count  = parity_errors_next;
        res.framing_error_count = framing_errors_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_address_reg <= STATION_ADDRESS_RESET;
            crc_reg             <= CRC_INIT;
            byte_count_reg      <= '0;
            address_reg         <= 8'd0;
            function_reg        <= 8'd0;
            frames_reg          <= 16'd0;
            crc_errors_reg      <= 16'd0;
            short_frames_reg    <= 16'd0;
            overflows_reg       <= 16'd0;
            overruns_reg        <= 16'd0;
            parity_errors_reg   <= 16'd0;
            framing_errors_reg  <= 16'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                station_address_reg <= cfg_data;
            end
            crc_reg            <= crc_next;
            byte_count_reg     <= byte_count_next;
            address_reg        <= address_next;
            function_reg       <= function_next;
            frames_reg         <= frames_next;
            crc_errors_reg     <= crc_errors_next;
            short_frames_reg   <= short_frames_next;
            overflows_reg      <= overflows_next;
            overruns_reg       <= overruns_next;
            parity_errors_reg  <= parity_errors_next;
            framing_errors_reg <= framing_errors_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= BYTE_COUNT_W'(MAX_FRAME_BYTES))
        else $error("byte count beyond maximum frame length");

    a_gap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (byte_count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame not restarted after gap");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg == '0) |-> (crc_reg == CRC_INIT && address_reg == 8'd0
                                    && function_reg == 8'd0))
        else $error("empty frame carries stale state");

    a_frames_step: assert property (@(posedge clk) disable iff (!rst_n)
        !res_push |=> $stable(frames_reg))
        else $error("frame count moved without a gap");

endmodule

// ----- hw/rtl/mrtu_out_stage.sv -----
// Result register of the framer: holds one frame report until transferred.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_push,
    input  mrtu_pkg::result_t res,
    output logic              res_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mrtu_pkg::result_t out_res
);
    import mrtu_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/modbus_rtu_frame_receiver_unit.sv -----
// Modbus RTU slave receive framer: takes one byte or gap transfer per clock
// while no gap is held back, and reports one frame summary with statistics
// for every gap. Each transfer passes an input register, the combinational
// CRC byte-update network and counters, and a result register: a report is
// offered on the output once its gap has been written into the result
// register. A gap waits in the input register only while an untaken report
// fills the output.
// Byte transfers produce no output. Write station_address only while idle.
// Depends on mrtu_pkg, mrtu_in_stage, mrtu_frame_core, mrtu_out_stage.
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,       // station_address
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // rx_byte, overrun_error, parity_error,
                                         // framing_error, zero fill
    input  logic         s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // frame_address, function_code, pdu_length,
                                         // frame_count, crc_error_count,
                                         // short_frame_count, overflow_count,
                                         // overrun_count, parity_error_count,
                                         // framing_error_count
    output logic [2:0]   m_axis_tuser    // frame_status
);
    import mrtu_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    logic    res_ready;
    logic    res_push;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_item.command       = command_t'(s_axis_tuser);
        in_item.rx_byte       = s_axis_tdata[7:0];
        in_item.overrun_error = s_axis_tdata[8];
        in_item.parity_error  = s_axis_tdata[9];
        in_item.framing_error = s_axis_tdata[10];
    end

    mrtu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    mrtu_frame_core u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_push   (res_push),
        .res        (res)
    );

    mrtu_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.frame_status;
    assign m_axis_tdata = {out_res.framing_error_count,
                           out_res.parity_error_count,
                           out_res.overrun_count,
                           out_res.overflow_count,
                           out_res.short_frame_count,
                           out_res.crc_error_count,
                           out_res.frame_count,
                           out_res.pdu_length,
                           out_res.function_code,
                           out_res.frame_address};

endmodule
